// ----- hdl/tbl_pkg.sv -----
package tbl_pkg;

  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  localparam logic [15:0] CAPACITY_RESET  = 16'd100;
  localparam logic [31:0] FILL_RATE_RESET = 32'd65536;

  // Configuration register indexes
  localparam int unsigned    CFG_INDEX_W   = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILL_RATE = 1'b1;

  typedef struct packed {
    logic [31:0] elapsed_ticks;
    logic [15:0] tokens_wanted;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [31:0] wait_ticks;
    logic [15:0] level_whole;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REFILL,
    ST_DECIDE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic refill;
    logic decide;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } status_t;

  // Level ceiling: capacity in fixed point, saturated to 32 bits
  function automatic logic [31:0] level_limit(input logic [15:0] cap,
                                              input int unsigned frac);
    logic [63:0] wide;
    wide = 64'(cap) << frac;
    return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

endpackage

// ----- hdl/tbl_ctrl.sv -----
module tbl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tbl_pkg::status_t status_i,
  output tbl_pkg::cmd_t    cmd_o
);

  tbl_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tbl_pkg::ST_IDLE:   if (in_valid_i) state_d = tbl_pkg::ST_MUL;
      tbl_pkg::ST_MUL:    state_d = tbl_pkg::ST_REFILL;
      tbl_pkg::ST_REFILL: state_d = tbl_pkg::ST_DECIDE;
      tbl_pkg::ST_DECIDE: begin
        state_d = status_i.need_div ? tbl_pkg::ST_DIV : tbl_pkg::ST_DONE;
      end
      tbl_pkg::ST_DIV:    if (status_i.div_last) state_d = tbl_pkg::ST_DONE;
      tbl_pkg::ST_DONE:   if (out_free) state_d = tbl_pkg::ST_IDLE;
      default:            state_d = tbl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tbl_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      tbl_pkg::ST_MUL:    cmd_o.mul      = 1'b1;
      tbl_pkg::ST_REFILL: cmd_o.refill   = 1'b1;
      tbl_pkg::ST_DECIDE: cmd_o.decide   = 1'b1;
      tbl_pkg::ST_DIV:    cmd_o.div_step = 1'b1;
      tbl_pkg::ST_DONE:   cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/tbl_dp.sv -----
module tbl_dp #(
  parameter int unsigned FRAC_BITS = tbl_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tbl_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  tbl_pkg::req_t                   in_data_i,
  output tbl_pkg::rsp_t                   out_data_o,
  input  tbl_pkg::cmd_t                   cmd_i,
  output tbl_pkg::status_t                status_o
);

  localparam int unsigned NEED_W = 16 + FRAC_BITS;
  localparam int unsigned CNT_W  = $clog2(NEED_W);
  localparam logic [31:0] LEVEL_RESET =
    tbl_pkg::level_limit(tbl_pkg::CAPACITY_RESET, FRAC_BITS);

  logic [15:0]       cap_q;
  logic [31:0]       rate_q;
  logic [31:0]       level_q;
  logic [31:0]       elapsed_q;
  logic [15:0]       wanted_q;
  logic [63:0]       prod_q;
  logic [31:0]       rlvl_q, rlvl_d;
  logic [NEED_W-1:0] dvd_q;
  logic [31:0]       rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              granted_q;
  logic              zero_rate_q;
  tbl_pkg::rsp_t     out_q;

  logic [31:0] limit;
  logic [32:0] sum;
  logic [63:0] need_wide;
  logic [63:0] short_wide;
  logic        fits;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        qbit;
  logic [63:0] quot_wide;
  logic [31:0] wait_sat;
  logic [31:0] level_sh;

  assign limit = tbl_pkg::level_limit(cap_q, FRAC_BITS);

  // Refill: saturate the product against the ceiling before the add
  assign sum = {1'b0, level_q} + {1'b0, prod_q[31:0]};
  always_comb begin
    if (prod_q >= {32'b0, limit}) begin
      rlvl_d = limit;
    end else if (sum > {1'b0, limit}) begin
      rlvl_d = limit;
    end else begin
      rlvl_d = sum[31:0];
    end
  end

  assign need_wide  = 64'(wanted_q) << FRAC_BITS;
  assign fits       = {32'b0, rlvl_q} >= need_wide;
  assign short_wide = need_wide - {32'b0, rlvl_q};

  // One restoring-division step per cycle, quotient shifts into dvd_q
  assign rem_sh  = {rem_q, dvd_q[NEED_W-1]};
  assign qbit    = rem_sh >= {1'b0, rate_q};
  assign rem_sub = qbit ? (rem_sh - {1'b0, rate_q}) : rem_sh;

  assign quot_wide = 64'(dvd_q);
  assign wait_sat  = (quot_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot_wide[31:0];
  assign level_sh  = level_q >> FRAC_BITS;

  assign status_o.need_div = !fits && (rate_q != 32'd0);
  assign status_o.div_last = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= tbl_pkg::CAPACITY_RESET;
      rate_q  <= tbl_pkg::FILL_RATE_RESET;
      level_q <= LEVEL_RESET;
    end else begin
      if (cfg_we_i && cfg_index_i == tbl_pkg::CFG_CAPACITY) begin
        cap_q <= cfg_data_i[15:0];
      end
      if (cfg_we_i && cfg_index_i == tbl_pkg::CFG_FILL_RATE) begin
        rate_q <= cfg_data_i;
      end
      if (cmd_i.decide) begin
        level_q <= fits ? (rlvl_q - need_wide[31:0]) : rlvl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      elapsed_q <= in_data_i.elapsed_ticks;
      wanted_q  <= in_data_i.tokens_wanted;
    end
    if (cmd_i.mul) begin
      prod_q <= 64'(elapsed_q) * 64'(rate_q);
    end
    if (cmd_i.refill) begin
      rlvl_q <= rlvl_d;
    end
    if (cmd_i.decide) begin
      granted_q   <= fits;
      zero_rate_q <= (rate_q == 32'd0);
      dvd_q       <= short_wide[NEED_W-1:0];
      rem_q       <= '0;
      cnt_q       <= CNT_W'(NEED_W - 1);
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_sub[31:0];
      dvd_q <= {dvd_q[NEED_W-2:0], qbit};
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.load_out) begin
      out_q.granted     <= granted_q;
      out_q.wait_ticks  <= granted_q   ? 32'd0 :
                           zero_rate_q ? 32'hFFFF_FFFF : wait_sat;
      out_q.level_whole <= level_sh[15:0];
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- hdl/token_bucket_limiter.sv -----
// Single token bucket rate limiter.
//
// Request channel (in_valid_i / in_ready_o / in_data_i): one transfer per
// request, carrying the ticks since the previous request and the whole
// tokens wanted. Result channel (out_valid_o / out_ready_i / out_data_o):
// one transfer per request with the grant flag, the wait in ticks when
// refused, and the whole part of the bucket level afterwards.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i /
// cfg_data_i): index 0 writes the capacity, index 1 the fill rate. Always
// ready; write it only while no request is in flight.
//
// A request transfer is followed by the multiply, refill and decide steps;
// a request refused at a nonzero rate then runs the bit-serial restoring
// divider that computes the wait, before the result is loaded. One request
// is worked on at a time, so the next request is taken only once the
// previous result is loaded into the output register. Reset restores
// capacity 100, rate 1.0 token per tick at FRAC_BITS = 16, and a full bucket.
// The result sits in an output register; while the receiver stalls, the
// next request is accepted and computed, then held until the register frees.
module token_bucket_limiter #(
  parameter int unsigned FRAC_BITS = tbl_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tbl_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tbl_pkg::req_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tbl_pkg::rsp_t                   out_data_o
);

  tbl_pkg::cmd_t    cmd;
  tbl_pkg::status_t status;

  // Register writes always complete on the transfer, so never stall the config channel
  assign cfg_ready_o = 1'b1;

  tbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tbl_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // A request transfer starts work; no second request until it finishes
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // A granted result never reports a wait
  a_grant_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |-> out_data_o.wait_ticks == 32'd0)
    else $error("granted result with nonzero wait");

  // A new result appears only after the datapath went through its steps
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result raised straight from idle");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FRAC = tbl_pkg::FRAC_BITS_DEFAULT;
  localparam int unsigned QUIET_LIMIT = 3000;  // cycles with no transfer before giving up
  localparam int unsigned DRAIN_CYCLES = 50;   // longest request latency plus margin

  // How the two sides idle during a phase
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  logic clk_i;
  logic rst_ni;

  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [tbl_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [31:0]                     cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  tbl_pkg::req_t                   in_data_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  tbl_pkg::rsp_t                   out_data_o;

  token_bucket_limiter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Bucket mirror: the settings and level the block should hold right now
  logic [15:0] cap_setting;
  logic [31:0] rate_setting;
  logic [31:0] bucket_level;

  tbl_pkg::req_t pending_reqs[$];    // requests waiting for the driver
  tbl_pkg::rsp_t expected_rsps[$];   // grant decisions waiting for the block to report
  idle_e idle_mode;
  bit req_taken;            // set on a request transfer, cleared by the driver
  int mismatches;
  int unsigned quiet_cycles;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Refill the mirrored bucket, then grant or refuse the request and work out
  // the wait. Advance the mirrored level as a side effect.
  function automatic tbl_pkg::rsp_t admit_request(input tbl_pkg::req_t r);
    logic [63:0] ceiling;
    logic [63:0] refill;
    logic [63:0] lvl;
    logic [63:0] need;
    logic [63:0] quo;
    tbl_pkg::rsp_t res;
    ceiling = 64'(cap_setting) << FRAC;
    if (ceiling > 64'hFFFF_FFFF) begin
      ceiling = 64'hFFFF_FFFF;
    end
    // Compare the full product with the ceiling so a huge refill saturates
    refill = 64'(r.elapsed_ticks) * 64'(rate_setting);
    if (refill >= ceiling) begin
      lvl = ceiling;
    end else begin
      // A lowered capacity clamps the old level here
      lvl = 64'(bucket_level) + refill;
      if (lvl > ceiling) begin
        lvl = ceiling;
      end
    end
    need = 64'(r.tokens_wanted) << FRAC;
    res = '0;
    if (lvl >= need) begin
      lvl = lvl - need;
      res.granted = 1'b1;
    end else if (rate_setting == 32'd0) begin
      // Nothing ever refills: report the longest wait
      res.wait_ticks = '1;
    end else begin
      quo = (need - lvl) / 64'(rate_setting);
      res.wait_ticks = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    end
    bucket_level = lvl[31:0];
    res.level_whole = lvl[FRAC+15:FRAC];
    return res;
  endfunction

  // Draw a request that mostly fits the current capacity, so grants and
  // refusals both happen often; now and then use fully random fields.
  function automatic tbl_pkg::req_t random_request();
    tbl_pkg::req_t r;
    int unsigned pick;
    int unsigned cap;
    cap = cap_setting;
    pick = $urandom_range(99);
    if (pick < 35) begin
      r.elapsed_ticks = 32'd0;
    end else if (pick < 70) begin
      r.elapsed_ticks = $urandom_range(4);
    end else if (pick < 85) begin
      r.elapsed_ticks = $urandom_range(300);
    end else if (pick < 95) begin
      r.elapsed_ticks = $urandom_range(65535);
    end else begin
      r.elapsed_ticks = $urandom();
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      r.tokens_wanted = 16'd0;
    end else if (pick < 60) begin
      r.tokens_wanted = 16'($urandom_range(cap / 8 + 1));
    end else if (pick < 85) begin
      r.tokens_wanted = 16'($urandom_range(cap + 1));
    end else if (pick < 95) begin
      r.tokens_wanted = 16'($urandom_range(cap + 10, cap));
    end else begin
      r.tokens_wanted = 16'($urandom());
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0h, actual %0h", what, want, got);
    end
  endtask

  task automatic send(input logic [31:0] elapsed, input logic [15:0] wanted);
    tbl_pkg::req_t r;
    r.elapsed_ticks = elapsed;
    r.tokens_wanted = wanted;
    pending_reqs.push_back(r);
  endtask

  // Hold until every queued request has been sent and answered
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0);
  endtask

  // Write one register; call only while the block is idle
  task automatic write_reg(input logic [tbl_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    // Only the low half of a capacity write counts
    if (idx == tbl_pkg::CFG_CAPACITY) begin
      cap_setting = value[15:0];
    end else begin
      rate_setting = value;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int count, input idle_e mode);
    idle_mode = mode;
    repeat (count) pending_reqs.push_back(random_request());
    wait_idle();
  endtask

  // Request driver: change inputs on the falling edge, hold valid and the
  // payload until the transfer, then pick the next request or idle.
  always @(negedge clk_i) begin : request_driver
    bit hold_off;
    if (!in_valid_i || req_taken) begin
      req_taken = 1'b0;
      hold_off = (idle_mode == IDLE_SEND && $urandom_range(99) < 62) ||
                 (idle_mode == IDLE_BOTH && $urandom_range(99) < 25);
      if (pending_reqs.size() != 0 && !hold_off) begin
        in_data_i  <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: stall at random per the phase
  always @(negedge clk_i) begin
    case (idle_mode)
      IDLE_RECV: begin
        out_ready_i <= ($urandom_range(99) >= 62);
      end
      IDLE_BOTH: begin
        out_ready_i <= ($urandom_range(99) >= 25);
      end
      default: begin
        out_ready_i <= 1'b1;
      end
    endcase
  end

  // Monitor: predict on each request transfer, check each result transfer
  // against the oldest prediction.
  always @(posedge clk_i) begin : result_monitor
    tbl_pkg::rsp_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_rsps.push_back(admit_request(in_data_i));
        req_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          flag_mismatch("result with nothing pending", 32'd0, out_data_o.wait_ticks);
        end else begin
          want = expected_rsps.pop_front();
          if (out_data_o.granted !== want.granted) begin
            flag_mismatch("granted", 32'(want.granted), 32'(out_data_o.granted));
          end
          if (out_data_o.wait_ticks !== want.wait_ticks) begin
            flag_mismatch("wait_ticks", want.wait_ticks, out_data_o.wait_ticks);
          end
          if (out_data_o.level_whole !== want.level_whole) begin
            flag_mismatch("level_whole", 32'(want.level_whole), 32'(out_data_o.level_whole));
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_valid_i  = 1'b0;
    cfg_index_i  = tbl_pkg::CFG_CAPACITY;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b1;
    rst_ni       = 1'b0;
    idle_mode    = IDLE_NONE;
    req_taken    = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    // Reset leaves the default capacity and rate with a full bucket
    cap_setting  = tbl_pkg::CAPACITY_RESET;
    rate_setting = tbl_pkg::FILL_RATE_RESET;
    bucket_level = 32'(tbl_pkg::CAPACITY_RESET) << FRAC;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default settings: take nothing, drain the bucket, refuse, refill,
    // overflow the refill, ask past capacity, partial refills.
    send(32'd0, 16'd0);
    send(32'd0, 16'd100);
    send(32'd0, 16'd1);
    send(32'd5, 16'd3);
    send(32'hFFFF_FFFF, 16'd0);
    send(32'd0, 16'hFFFF);
    send(32'd0, 16'd50);
    send(32'd3, 16'd60);
    wait_idle();

    // Zero rate: refusals report the longest wait
    write_reg(tbl_pkg::CFG_FILL_RATE, 32'd0);
    send(32'd0, 16'd200);
    send(32'd7, 16'd0);
    wait_idle();

    // Widest capacity and fastest rate: fill, empty in one go, refill
    write_reg(tbl_pkg::CFG_CAPACITY, 32'h0000_FFFF);
    write_reg(tbl_pkg::CFG_FILL_RATE, 32'hFFFF_FFFF);
    send(32'd1, 16'd0);
    send(32'd0, 16'hFFFF);
    send(32'd2, 16'd0);
    wait_idle();

    // Lower the capacity under a full bucket; the next refill clamps it
    write_reg(tbl_pkg::CFG_CAPACITY, 32'd1);
    send(32'd0, 16'd0);
    send(32'd0, 16'd2);
    wait_idle();

    // Zero capacity keeps the bucket empty
    write_reg(tbl_pkg::CFG_CAPACITY, 32'd0);
    send(32'd9, 16'd0);
    send(32'd0, 16'd1);
    wait_idle();

    // Random requests over a spread of settings and idling patterns
    write_reg(tbl_pkg::CFG_CAPACITY, {16'($urandom()), 16'd100});
    write_reg(tbl_pkg::CFG_FILL_RATE, 32'h0000_8000);
    run_random(80, IDLE_SEND);

    write_reg(tbl_pkg::CFG_CAPACITY, {16'($urandom()), 16'd1});
    write_reg(tbl_pkg::CFG_FILL_RATE, 32'h0000_4000);
    run_random(80, IDLE_RECV);

    write_reg(tbl_pkg::CFG_CAPACITY, {16'($urandom()), 16'hFFFF});
    write_reg(tbl_pkg::CFG_FILL_RATE, 32'hFFFF_FFFF);
    run_random(80, IDLE_BOTH);

    // Slowest rate: long waits through the divider
    write_reg(tbl_pkg::CFG_CAPACITY, 32'h0000_FFFF);
    write_reg(tbl_pkg::CFG_FILL_RATE, 32'd1);
    run_random(80, IDLE_NONE);

    write_reg(tbl_pkg::CFG_CAPACITY, 32'd20);
    write_reg(tbl_pkg::CFG_FILL_RATE, 32'd0);
    run_random(80, IDLE_SEND);

    write_reg(tbl_pkg::CFG_CAPACITY, $urandom());
    write_reg(tbl_pkg::CFG_FILL_RATE, $urandom());
    run_random(80, IDLE_RECV);

    write_reg(tbl_pkg::CFG_CAPACITY, {16'($urandom()), 16'($urandom_range(200, 1))});
    write_reg(tbl_pkg::CFG_FILL_RATE, $urandom_range(32'h0010_0000, 1));
    run_random(80, IDLE_BOTH);

    write_reg(tbl_pkg::CFG_CAPACITY, 32'd500);
    write_reg(tbl_pkg::CFG_FILL_RATE, 32'h0002_8000);
    run_random(80, IDLE_NONE);

    // Let any late or stray result show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
